[hdl/vmr_pkg.sv]
// ----------------------------------------------------------------------------
// vmr_pkg
// Shared constants, codes and request types of the visited map block.
// ----------------------------------------------------------------------------
package vmr_pkg;

  // map geometry
  localparam int MAX_POS   = 4096;
  localparam int POS_W     = $clog2(MAX_POS);
  localparam int CNT_W     = POS_W + 1;
  localparam int ROW_BITS  = 5;
  localparam int ROW_W     = 1 << ROW_BITS;
  localparam int ROW_IDX_W = POS_W - ROW_BITS;
  localparam int ROWS      = 1 << ROW_IDX_W;

  // stream payload widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // operation codes
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_PUSH  = 3'd1,
    OP_NEXT  = 3'd2,
    OP_MARK  = 3'd3,
    OP_RANGE = 3'd4,
    OP_QUERY = 3'd5
  } op_t;

  // request to the bitmap rows
  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic                 clr;
    logic [ROW_IDX_W-1:0] row;
    logic [ROW_W-1:0]     wdata;
  } bm_req_t;

  // request to the order stack
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [POS_W-1:0] addr;
    logic [POS_W-1:0] wdata;
  } stk_req_t;

  // bits lo .. hi-1 of one row set
  function automatic logic [ROW_W-1:0] range_mask(input logic [ROW_BITS-1:0] lo,
                                                  input logic [ROW_BITS:0]   hi);
    logic [ROW_W-1:0] m;
    for (int i = 0; i < ROW_W; i++) begin
      m[i] = (ROW_BITS'(i) >= lo) && ((ROW_BITS+1)'(i) < hi);
    end
    return m;
  endfunction

endpackage

[hdl/visited_map_with_random_order.sv]
// ----------------------------------------------------------------------------
// visited_map_with_random_order
// Visited bitmap, software-loaded visit order stack and unvisited count,
// run by a small sequencer around one shared row mask and bit count unit.
// ----------------------------------------------------------------------------
//  channel | ports                     | contents
//  --------+---------------------------+---------------------------------------
//  input   | in_tvalid/tready/tdata    | op, position, range_end
//  result  | out_tvalid/tready/tdata   | found, found_position, is_marked,
//          |                           | remaining
//  config  | cfg_wen/cfg_wdata         | capacity
//
//  start, push, spare codes and a query outside capacity go straight to the result;
//  a query first reads its row; a mark is a one-position range, empty outside capacity
//  next unvisited pops entries one by one, dropping those outside capacity and
//  reading the row of the rest, until it finds an unvisited one or the stack is empty
//  mark range: a read, then an update pass per 32-bit row touched
//  reset is synchronous and clears the map at once through per-row valid flags
//  a waiting result holds in the output register; the next request is taken
//  meanwhile and only its own completion waits for the output to drain
// ----------------------------------------------------------------------------
module visited_map_with_random_order
  import vmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // op [2:0], position [14:3], range_end [27:15]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // found [0], found_position [12:1], is_marked [13], remaining [26:14]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wen,
  input  logic [CNT_W-1:0]      cfg_wdata
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_POP  = 8'b0000_0010,
    S_SRD  = 8'b0000_0100,
    S_BCHK = 8'b0000_1000,
    S_RNG  = 8'b0001_0000,
    S_RUPD = 8'b0010_0000,
    S_QCHK = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cap_r;
  logic [CNT_W-1:0]     depth_r, depth_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     cur_r, cur_nxt;
  logic [CNT_W-1:0]     stop_r, stop_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     entry_r, entry_nxt;
  logic                 found_r, found_nxt;
  logic [POS_W-1:0]     fpos_r, fpos_nxt;
  logic                 marked_r, marked_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  bm_req_t              bm_req;
  stk_req_t             stk_req;
  logic [ROW_W-1:0]     bm_rdata;
  logic [POS_W-1:0]     stk_rdata;

  logic [CNT_W-1:0]     cap_eff;
  logic                 in_fire;
  op_t                  in_op;
  logic [POS_W-1:0]     in_pos;
  logic [CNT_W-1:0]     in_rend;
  logic [CNT_W-1:0]     pos_ext;
  logic [CNT_W-1:0]     pos_inc;
  logic [ROW_BITS:0]    row_hi;
  logic [ROW_W-1:0]     row_mask;
  logic [ROW_W-1:0]     new_bits;
  logic [CNT_W-1:0]     new_cnt;

  vmr_bitmap u_bitmap (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (bm_req),
    .rdata (bm_rdata)
  );

  vmr_stack u_stack (
    .clk   (clk),
    .req   (stk_req),
    .rdata (stk_rdata)
  );

  // request fields and effective capacity
  assign in_op   = op_t'(in_tdata[2:0]);
  assign in_pos  = in_tdata[3 +: POS_W];
  assign in_rend = in_tdata[3+POS_W +: CNT_W];
  assign in_fire = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cap_eff = (cap_r > CNT_W'(MAX_POS)) ? CNT_W'(MAX_POS) : cap_r;
  assign pos_ext = {1'b0, in_pos};
  assign pos_inc = pos_ext + CNT_W'(1);

  // shared row unit: mask of the range inside the current row, newly set bits
  assign row_hi   = (stop_r[CNT_W-1:ROW_BITS] == cur_r[CNT_W-1:ROW_BITS]) ?
                    {1'b0, stop_r[ROW_BITS-1:0]} : (ROW_BITS+1)'(ROW_W);
  assign row_mask = range_mask(cur_r[ROW_BITS-1:0], row_hi);
  assign new_bits = row_mask & ~bm_rdata;
  always_comb begin
    logic [CNT_W-1:0] pc;
    pc      = CNT_W'($countones(new_bits));
    new_cnt = (cnt_r > pc) ? (cnt_r - pc) : '0;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    depth_nxt  = depth_r;
    cnt_nxt    = cnt_r;
    cur_nxt    = cur_r;
    stop_nxt   = stop_r;
    pos_nxt    = pos_r;
    entry_nxt  = entry_r;
    found_nxt  = found_r;
    fpos_nxt   = fpos_r;
    marked_nxt = marked_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    bm_req     = '0;
    stk_req    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          found_nxt  = 1'b0;
          fpos_nxt   = '0;
          marked_nxt = 1'b0;
          pos_nxt    = in_pos;
          cur_nxt    = pos_ext;
          state_nxt  = S_DONE;
          case (in_op)
            OP_START: begin
              bm_req.clr = 1'b1;
              depth_nxt  = '0;
              cnt_nxt    = cap_eff;
            end
            OP_PUSH: begin
              if (depth_r < CNT_W'(MAX_POS)) begin
                stk_req.wr    = 1'b1;
                stk_req.addr  = depth_r[POS_W-1:0];
                stk_req.wdata = in_pos;
                depth_nxt     = depth_r + CNT_W'(1);
              end
            end
            OP_NEXT: begin
              state_nxt = S_POP;
            end
            OP_MARK: begin
              stop_nxt  = (pos_inc < cap_eff) ? pos_inc : cap_eff;
              state_nxt = S_RNG;
            end
            OP_RANGE: begin
              stop_nxt  = (in_rend < cap_eff) ? in_rend : cap_eff;
              state_nxt = S_RNG;
            end
            OP_QUERY: begin
              if (pos_ext < cap_eff) begin
                bm_req.rd  = 1'b1;
                bm_req.row = in_pos[POS_W-1:ROW_BITS];
                state_nxt  = S_QCHK;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      // pop one entry, or report none
      S_POP: begin
        if (depth_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          depth_nxt    = depth_r - CNT_W'(1);
          stk_req.rd   = 1'b1;
          stk_req.addr = depth_nxt[POS_W-1:0];
          state_nxt    = S_SRD;
        end
      end
      // popped entry ready: drop it if outside capacity, else fetch its row
      S_SRD: begin
        entry_nxt = stk_rdata;
        if ({1'b0, stk_rdata} < cap_eff) begin
          bm_req.rd  = 1'b1;
          bm_req.row = stk_rdata[POS_W-1:ROW_BITS];
          state_nxt  = S_BCHK;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_BCHK: begin
        if (bm_rdata[entry_r[ROW_BITS-1:0]]) begin
          state_nxt = S_POP;
        end else begin
          found_nxt = 1'b1;
          fpos_nxt  = entry_r;
          state_nxt = S_DONE;
        end
      end
      // range walk, one row per pass
      S_RNG: begin
        if (cur_r < stop_r) begin
          bm_req.rd  = 1'b1;
          bm_req.row = cur_r[POS_W-1:ROW_BITS];
          state_nxt  = S_RUPD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RUPD: begin
        bm_req.wr    = 1'b1;
        bm_req.row   = cur_r[POS_W-1:ROW_BITS];
        bm_req.wdata = bm_rdata | row_mask;
        cnt_nxt      = new_cnt;
        cur_nxt      = {cur_r[CNT_W-1:ROW_BITS] + (CNT_W-ROW_BITS)'(1), {ROW_BITS{1'b0}}};
        state_nxt    = S_RNG;
      end
      S_QCHK: begin
        marked_nxt = bm_rdata[pos_r[ROW_BITS-1:0]];
        state_nxt  = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {(OUT_DATA_W-CNT_W-POS_W-2)'(0), cnt_r, marked_r, fpos_r,
                           found_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CNT_W'(MAX_POS);
      depth_r     <= '0;
      cnt_r       <= CNT_W'(MAX_POS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    stop_r     <= stop_nxt;
    pos_r      <= pos_nxt;
    entry_r    <= entry_nxt;
    found_r    <= found_nxt;
    fpos_r     <= fpos_nxt;
    marked_r   <= marked_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POS))
    else $error("unvisited count above map size");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CNT_W'(MAX_POS))
    else $error("stack depth above map size");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("request taken while previous one still in flight");

  a_pop_lowers_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) && (depth_r != '0) |=> depth_r == $past(depth_r) - CNT_W'(1))
    else $error("pop did not lower stack depth");

  a_cnt_only_falls: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(in_fire && (in_op == OP_START)) |-> cnt_r <= $past(cnt_r))
    else $error("unvisited count rose without start");

endmodule

[hdl/vmr_bitmap.sv]
// ----------------------------------------------------------------------------
// vmr_bitmap
// Visited bits stored as rows of one word, with a valid flag per row so that
// a start clears the whole map at once.
// ----------------------------------------------------------------------------
module vmr_bitmap
  import vmr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  bm_req_t          req,
  output logic [ROW_W-1:0] rdata
);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_valid_r;
  logic [ROW_W-1:0] rdata_r;
  logic             rvalid_r;

  // row storage, registered read
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.row] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[req.row];
    end
  end

  // row valid flags, cleared together on reset or start
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      row_valid_r <= '0;
      rvalid_r    <= 1'b0;
    end else begin
      if (req.wr) begin
        row_valid_r[req.row] <= 1'b1;
      end
      if (req.rd) begin
        rvalid_r <= row_valid_r[req.row];
      end
    end
  end

  // a row never written since start reads as clear
  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

[hdl/vmr_stack.sv]
// ----------------------------------------------------------------------------
// vmr_stack
// Order stack storage: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module vmr_stack
  import vmr_pkg::*;
(
  input  logic             clk,
  input  stk_req_t         req,
  output logic [POS_W-1:0] rdata
);

  logic [POS_W-1:0] mem [MAX_POS];
  logic [POS_W-1:0] rdata_r;

  // entry storage
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[test/vmr_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vmr_checker
// Watches the request, result and capacity ports of the visited map, keeps
// its own copy of the bitmap, visit order stack and unvisited count, and
// compares every result with the oldest predicted one.
// ----------------------------------------------------------------------------
module vmr_checker
  import vmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // op [2:0], position [14:3], range_end [27:15]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // found [0], found_position [12:1], is_marked [13], remaining [26:14]
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wen,
  input  logic [CNT_W-1:0]      cfg_wdata,
  output int                    fail_count,
  output int                    results_seen,
  output int                    still_expected
);

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] found_pos;
    logic             is_marked;
    logic [CNT_W-1:0] remaining;
  } map_answer_t;

  // mirrored map state
  bit               visited [MAX_POS];
  logic [POS_W-1:0] visit_order [MAX_POS];
  int               order_depth;
  int               unvisited;
  int               capacity;

  map_answer_t answer_q [$];
  int          mismatches;
  int          seen;

  function automatic int usable_capacity();
    return (capacity < MAX_POS) ? capacity : MAX_POS;
  endfunction

  // count goes down once per newly visited bit and never below zero
  function automatic void visit(int p, int cap);
    if (p < cap && !visited[p]) begin
      visited[p] = 1'b1;
      if (unvisited > 0) unvisited--;
    end
  endfunction

  function automatic map_answer_t predict_answer(logic [2:0] code, logic [POS_W-1:0] pos,
                                                 logic [CNT_W-1:0] rend);
    int          cap;
    int          stop;
    int          entry;
    int          i;
    map_answer_t a;
    cap = usable_capacity();
    a   = '0;
    case (code)
      OP_START: begin
        foreach (visited[k]) visited[k] = 1'b0;
        order_depth = 0;
        unvisited   = cap;
      end
      OP_PUSH: begin
        // a full stack drops the entry
        if (order_depth < MAX_POS) begin
          visit_order[order_depth] = pos;
          order_depth++;
        end
      end
      OP_NEXT: begin
        // pop past visited entries and entries outside capacity
        while (order_depth > 0 && !a.found) begin
          order_depth--;
          entry = int'(visit_order[order_depth]);
          if (entry < cap && !visited[entry]) begin
            a.found     = 1'b1;
            a.found_pos = visit_order[order_depth];
          end
        end
      end
      OP_MARK: visit(int'(pos), cap);
      OP_RANGE: begin
        stop = (int'(rend) < cap) ? int'(rend) : cap;
        for (i = int'(pos); i < stop; i++) visit(i, cap);
      end
      OP_QUERY: begin
        if (int'(pos) < cap) a.is_marked = visited[pos];
      end
      default: ;
    endcase
    a.remaining = unvisited[CNT_W-1:0];
    return a;
  endfunction

  function automatic void report(string what, map_answer_t want, map_answer_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected found=%0d pos=%0d marked=%0d remaining=%0d, got found=%0d pos=%0d marked=%0d remaining=%0d",
               $realtime, what, want.found, want.found_pos, want.is_marked, want.remaining,
               got.found, got.found_pos, got.is_marked, got.remaining);
    end
  endfunction

  // results first, then capacity writes, then new requests
  always @(posedge clk) begin : watch
    map_answer_t got;
    map_answer_t want;
    if (!rst_n) begin
      foreach (visited[k]) visited[k] = 1'b0;
      order_depth = 0;
      capacity    = MAX_POS;
      unvisited   = MAX_POS;
      answer_q.delete();
      mismatches  = 0;
      seen        = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.found     = out_tdata[0];
        got.found_pos = out_tdata[12:1];
        got.is_marked = out_tdata[13];
        got.remaining = out_tdata[26:14];
        seen++;
        if (answer_q.size() == 0) begin
          report("result with nothing outstanding", '0, got);
        end else begin
          want = answer_q.pop_front();
          if (got.found !== want.found || got.found_pos !== want.found_pos ||
              got.is_marked !== want.is_marked || got.remaining !== want.remaining) begin
            report($sformatf("result %0d differs", seen), want, got);
          end
        end
      end
      if (cfg_wen) capacity = int'(cfg_wdata);
      if (in_tvalid && in_tready) begin
        answer_q.push_back(predict_answer(in_tdata[2:0], in_tdata[14:3], in_tdata[27:15]));
      end
    end
    fail_count     <= mismatches;
    results_seen   <= seen;
    still_expected <= answer_q.size();
  end

endmodule

[test/tb_visited_map_with_random_order.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_visited_map_with_random_order
// Drives start, push, next, mark, range and query requests into the visited
// map across many capacity settings, with random gaps and result stalls,
// and leaves the result comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_visited_map_with_random_order;
  import vmr_pkg::*;

  // op codes with no function in the block
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 1500;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_wen    = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata  = '0;

  int fail_count;
  int results_seen;
  int still_expected;

  int requests_sent   = 0;
  int send_gap_pct    = 0;
  int recv_stall_pct  = 0;
  int capacity_writes = 0;
  int cur_capacity    = MAX_POS;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  visited_map_with_random_order dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  vmr_checker answer_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .results_seen   (results_seen),
    .still_expected (still_expected)
  );

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // one request, held until accepted
  task automatic send_request(input logic [2:0] code, input logic [POS_W-1:0] pos,
                              input logic [CNT_W-1:0] rend);
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({rend, pos, code});
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_seen < requests_sent);
  endtask

  task automatic write_capacity(input int value);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value[CNT_W-1:0];
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cur_capacity = value;
    capacity_writes++;
  endtask

  // mostly inside capacity, sometimes at its edge or anywhere
  function automatic logic [POS_W-1:0] some_position(input int ecap);
    int pick;
    pick = $urandom_range(0, 99);
    if (ecap == 0 || pick < 12) return POS_W'($urandom_range(0, MAX_POS - 1));
    if (pick < 20) return POS_W'((ecap < MAX_POS) ? ecap : ecap - $urandom_range(1, 2));
    return POS_W'($urandom_range(0, ecap - 1));
  endfunction

  task automatic random_request(input int ecap);
    int               pick;
    logic [POS_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    pick = $urandom_range(0, 99);
    lo   = some_position(ecap);
    if (pick < 30) begin
      send_request(OP_NEXT, POS_W'($urandom), CNT_W'($urandom));
    end else if (pick < 48) begin
      send_request(OP_MARK, lo, CNT_W'($urandom));
    end else if (pick < 60) begin
      // short ranges mostly, some reversed, some wild ends, rare full sweeps
      case ($urandom_range(0, 19))
        0:       hi = CNT_W'($urandom);
        1:       begin lo = '0; hi = CNT_W'(MAX_POS); end
        2, 3:    hi = CNT_W'(lo) - CNT_W'($urandom_range(0, 8));
        default: hi = CNT_W'(lo) + CNT_W'($urandom_range(0, 40));
      endcase
      send_request(OP_RANGE, lo, hi);
    end else if (pick < 80) begin
      send_request(OP_QUERY, lo, CNT_W'($urandom));
    end else if (pick < 88) begin
      send_request(OP_PUSH, lo, CNT_W'($urandom));
    end else if (pick < 91) begin
      send_request(OP_START, POS_W'($urandom), CNT_W'($urandom));
    end else begin
      send_request(($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B,
                   POS_W'($urandom), CNT_W'($urandom));
    end
  endtask

  // capacity, start, a shuffled visit order, then a mix of requests
  task automatic run_episode();
    int               ecap;
    int               n;
    int               j;
    int               k;
    logic [POS_W-1:0] order [$];
    logic [POS_W-1:0] swap;
    if ($urandom_range(0, 5) != 0) begin
      case ($urandom_range(0, 19))
        0:       write_capacity(0);
        1:       write_capacity(1);
        2:       write_capacity(MAX_POS);
        3:       write_capacity((1 << CNT_W) - 1);
        4:       write_capacity($urandom_range(MAX_POS + 1, (1 << CNT_W) - 1));
        5:       write_capacity($urandom_range(65, MAX_POS - 1));
        default: write_capacity($urandom_range(2, 64));
      endcase
    end
    ecap = (cur_capacity < MAX_POS) ? cur_capacity : MAX_POS;
    // now and then keep the old count across a capacity change
    if ($urandom_range(0, 7) != 0) send_request(OP_START, POS_W'($urandom), CNT_W'($urandom));
    n = (ecap <= 48) ? ecap : $urandom_range(8, 48);
    for (j = 0; j < n; j++) begin
      order.push_back((ecap <= 48) ? POS_W'(j) : POS_W'($urandom_range(0, ecap - 1)));
    end
    for (j = n - 1; j > 0; j--) begin
      k        = $urandom_range(0, j);
      swap     = order[j];
      order[j] = order[k];
      order[k] = swap;
    end
    // stray entries: duplicates and positions outside capacity
    if ($urandom_range(0, 3) == 0) order.push_back(some_position(ecap));
    if (ecap < MAX_POS && $urandom_range(0, 3) == 0) begin
      order.push_back(POS_W'($urandom_range(ecap, MAX_POS - 1)));
    end
    foreach (order[m]) send_request(OP_PUSH, order[m], CNT_W'($urandom));
    repeat ($urandom_range(10, 40)) random_request(ecap);
  endtask

  // directed opening: extremes and the named corner cases
  task automatic directed_requests();
    send_request(OP_QUERY, '0, '0);
    send_request(OP_PUSH, POS_W'(MAX_POS - 1), '0);
    send_request(OP_PUSH, '0, '1);
    send_request(OP_PUSH, POS_W'(MAX_POS - 1), '0);
    send_request(OP_MARK, POS_W'(MAX_POS - 1), '0);
    send_request(OP_NEXT, '0, '0);
    send_request(OP_NEXT, '0, '0);
    send_request(OP_NEXT, '1, '1);
    send_request(OP_RANGE, POS_W'(100), CNT_W'(50));
    send_request(OP_RANGE, '0, CNT_W'(MAX_POS));
    send_request(OP_QUERY, POS_W'(MAX_POS - 1), '0);
    send_request(OP_MARK, '0, '0);
    send_request(OP_SPARE_A, '1, '1);
    send_request(OP_SPARE_B, '0, '0);
    send_request(OP_START, '1, '1);
    // small capacity, entries beyond it
    write_capacity(4);
    send_request(OP_START, '0, '0);
    send_request(OP_PUSH, POS_W'(2), '0);
    send_request(OP_PUSH, POS_W'(5), '0);
    send_request(OP_NEXT, '0, '0);
    send_request(OP_QUERY, POS_W'(5), '0);
    send_request(OP_MARK, POS_W'(7), '0);
    // wider capacity without start: count runs out and stays at zero
    write_capacity(8);
    send_request(OP_RANGE, '0, CNT_W'(8));
    send_request(OP_QUERY, POS_W'(6), '0);
    write_capacity(0);
    send_request(OP_START, '0, '0);
    send_request(OP_RANGE, '0, '1);
    write_capacity((1 << CNT_W) - 1);
    send_request(OP_START, '0, '0);
  endtask

  // stack a long visit order over a mostly visited map, then pop through it
  task automatic deep_order_stack();
    write_capacity(MAX_POS);
    send_request(OP_START, '0, '0);
    send_request(OP_RANGE, '0, CNT_W'(4000));
    repeat (200) send_request(OP_PUSH, POS_W'($urandom), CNT_W'($urandom));
    repeat (6) send_request(OP_NEXT, '0, '0);
    send_request(OP_QUERY, POS_W'(MAX_POS - 1), '0);
    send_request(OP_START, '0, '0);
    send_request(OP_NEXT, '0, '0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct   = 23;
    recv_stall_pct = 48;
    directed_requests();
    while (requests_sent < RANDOM_ITEMS / 3) run_episode();

    send_gap_pct   = 48;
    recv_stall_pct = 23;
    while (requests_sent < 2 * RANDOM_ITEMS / 3) run_episode();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    while (requests_sent < RANDOM_ITEMS) run_episode();
    deep_order_stack();

    drain();
    repeat (64) @(posedge clk);

    $display("covered %0d requests over %0d capacity writes, incl. a long visited pop",
             requests_sent, capacity_writes);
    $display("%0d results checked, %0d failed, %0d still outstanding",
             results_seen, fail_count, still_expected);
    if (fail_count == 0 && still_expected == 0) begin
      $display("visited_map_with_random_order: match");
    end else begin
      $display("visited_map_with_random_order: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("timed out after %0d requests, %0d results", requests_sent, results_seen);
    $display("visited_map_with_random_order: mismatch");
    $finish;
  end

endmodule
